// ===== hw/rtl/dps_pkg.sv =====
// Shared package of the damped pendulum step block: widths, fixed-point
// constants, register indexes, the datapath command and status types and the
// CORDIC arctangent table. Depends on nothing.
`default_nettype none

package dps_pkg;

  // Fixed-point configuration.
  localparam int FRAC_BITS     = 28;
  localparam int CORDIC_STAGES = 16;

  // Field and state widths.
  localparam int ANG_W      = FRAC_BITS + 4;
  localparam int RATE_W     = 32;
  localparam int COEF_W     = 16;
  localparam int PIX_W      = 12;
  localparam int START_W    = 31;
  localparam int COORD_W    = 14;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Internal widths.
  localparam int Q30        = 30;
  localparam int XY_W       = 33;
  localparam int Z_W        = 34;
  localparam int ZSH        = Q30 - FRAC_BITS;
  localparam int MUL_A_W    = COEF_W + 1;
  localparam int MUL_B_W    = XY_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = 36;
  localparam int T_W        = 46;
  localparam int R_W        = ((ANG_W > RATE_W) ? ANG_W : RATE_W) + 2;
  localparam int ITER_W     = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
  localparam int ATAN_LEN   = 24;
  localparam int ATAN_IDX_W = $clog2(ATAN_LEN);
  localparam int K_SHIFT    = 46 - FRAC_BITS;
  localparam int D_SHIFT    = 16;

  // Pi and related constants, worked out at elaboration, and the CORDIC gain in Q30.
  localparam longint PI_Q60        = 64'sh3243F6A8885A308D;
  localparam longint PI_FIX_L      = ((PI_Q60 >>> (59 - FRAC_BITS)) + 64'sd1) >>> 1;
  localparam longint TWO_PI_FIX_L  = 2 * PI_FIX_L;
  localparam longint PI_Q30_L      = ((PI_Q60 >>> 29) + 64'sd1) >>> 1;
  localparam longint HALF_PI_Q30_L = PI_Q30_L / 2;
  localparam longint GAIN_Q30_L    = 64'sd652032874;

  // Angle wrap runs as a restoring remainder against 2*pi.
  localparam int TWO_PI_BITS = $clog2(TWO_PI_FIX_L + 1);
  localparam int WRAP_SHIFT  = R_W - TWO_PI_BITS;
  localparam int WRAP_STEPS  = WRAP_SHIFT + 1;
  localparam int WCNT_W      = $clog2(WRAP_STEPS + 1);

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_STIFFNESS   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DAMPING     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ARM_LENGTH  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_START_ANGLE = 3'd5;

  // Register reset values.
  localparam logic [COEF_W-1:0]         STIFF_RESET = 16'd197;
  localparam logic [COEF_W-1:0]         DAMP_RESET  = 16'd197;
  localparam logic [PIX_W-1:0]          CX_RESET    = 12'd250;
  localparam logic [PIX_W-1:0]          CY_RESET    = 12'd500;
  localparam logic [PIX_W-1:0]          ARM_RESET   = 12'd200;
  localparam logic signed [START_W-1:0] START_RESET = 31'sd842887332;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CORDIC_START,
    OP_MUL_K,
    OP_MUL_D,
    OP_ACC_D,
    OP_WRAP_INIT_STEP,
    OP_WRAP_INIT_RESTART,
    OP_WRAP_STEP,
    OP_WRAP_FIX,
    OP_COMMIT_STEP,
    OP_COMMIT_RESTART,
    OP_MUL_X,
    OP_MUL_Y,
    OP_SUM_Y,
    OP_EMIT
  } dps_op_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic cordic_done;
    logic wrap_done;
    logic differs;
    logic out_free;
  } dps_status_t;

  // Arctangent of 2^-i in truncated Q30.
  function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dps_if.sv =====
// Channel interfaces of the damped pendulum step block: the tick input and
// the bob position output, each with valid, ready and payload.
// Depends on dps_pkg.
`default_nettype none

interface dps_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface dps_bob_if;
  import dps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] bob_x;
  logic signed [COORD_W-1:0] bob_y;

  modport source (output valid, output bob_x, output bob_y, input ready);
  modport sink   (input valid, input bob_x, input bob_y, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/damped_pendulum_step_top.sv =====
// Top level of the damped pendulum step block: controller and datapath.
// Depends on dps_pkg, dps_if, dps_ctrl and dps_datapath.
//
//   Channel  Dir  Handshake          Payload
//   tick     in   valid / ready      restart (1)
//   bob      out  valid / ready      bob_x (14, signed), bob_y (14, signed)
//   config   in   wr_en              wr_index (3), wr_data (31)
//
// One tick at a time. A step tick runs two passes of the serial CORDIC and
// the shift-subtract angle wrap; a restart tick runs the angle wrap only.
// A result waits in the output register; if a changed next result is ready
// before the sink takes the last one, the block holds in its final step.
// Reset is synchronous and clears state and configuration to defaults.
`default_nettype none

module damped_pendulum_step_top (
  input  logic                            clk,
  input  logic                            rst,
  dps_tick_if.sink                        tick,
  dps_bob_if.source                       bob,
  input  logic                            wr_en,
  input  logic [dps_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [dps_pkg::CFG_DATA_W-1:0]  wr_data
);
  import dps_pkg::*;

  dps_op_t     op;
  dps_status_t status;

  // Sequencer.
  dps_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick),
    .op     (op),
    .status (status)
  );

  // Arithmetic and state.
  dps_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .status   (status),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .bob      (bob)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/dps_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, then a
// registered step that applies the half-turn fold. Depends on dps_pkg.
`default_nettype none

module dps_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [dps_pkg::ANG_W-1:0]  angle,
  output logic                              done,
  output logic signed [dps_pkg::XY_W-1:0]   sin_q,
  output logic signed [dps_pkg::XY_W-1:0]   cos_q
);
  import dps_pkg::*;

  localparam logic signed [Z_W-1:0]  PI_Z   = Z_W'(PI_Q30_L);
  localparam logic signed [Z_W-1:0]  HALF_Z = Z_W'(HALF_PI_Q30_L);
  localparam logic signed [XY_W-1:0] GAIN   = XY_W'(GAIN_Q30_L);
  localparam logic [ITER_W-1:0]      LAST   = ITER_W'(CORDIC_STAGES - 1);

  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [Z_W-1:0]  z;
  logic                   neg;
  logic                   busy;
  logic                   fin;
  logic [ITER_W-1:0]      iter;

  logic signed [Z_W-1:0]  z_init;
  logic signed [Z_W-1:0]  z_fold;
  logic                   neg_fold;
  logic signed [XY_W-1:0] x_sh;
  logic signed [XY_W-1:0] y_sh;
  logic signed [Z_W-1:0]  atan_z;

  // Bring the angle to Q30 and fold it into [-pi/2, pi/2].
  assign z_init = Z_W'(angle) <<< ZSH;

  always_comb begin
    z_fold   = z_init;
    neg_fold = 1'b0;
    if (z_init > HALF_Z) begin
      z_fold   = z_init - PI_Z;
      neg_fold = 1'b1;
    end else if (z_init < -HALF_Z) begin
      z_fold   = z_init + PI_Z;
      neg_fold = 1'b1;
    end
  end

  // Shifted terms and table angle for the current micro-rotation.
  assign x_sh   = x >>> iter;
  assign y_sh   = y >>> iter;
  assign atan_z = $signed(Z_W'(atan_q30(ATAN_IDX_W'(iter))));

  // Iteration sequencing and the rotation registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= GAIN;
        y    <= '0;
        z    <= z_fold;
        neg  <= neg_fold;
        iter <= '0;
        busy <= 1'b1;
        fin  <= 1'b0;
      end else if (busy) begin
        if (!z[Z_W-1]) begin
          x <= x - y_sh;
          y <= y + x_sh;
          z <= z - atan_z;
        end else begin
          x <= x + y_sh;
          y <= y - x_sh;
          z <= z + atan_z;
        end
        iter <= iter + 1'b1;
        if (iter == LAST) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin   <= 1'b0;
        done  <= 1'b1;
        sin_q <= neg ? -y : y;
        cos_q <= neg ? -x : x;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dps_datapath.sv =====
// Datapath of the damped pendulum step block: configuration registers,
// pendulum state, shared multiplier, angle wrap unit, CORDIC and output
// register. Depends on dps_pkg, dps_if and dps_cordic.
`default_nettype none

module dps_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  dps_pkg::dps_op_t                  op,
  output dps_pkg::dps_status_t              status,
  input  logic                              wr_en,
  input  logic [dps_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [dps_pkg::CFG_DATA_W-1:0]    wr_data,
  dps_bob_if.source                         bob
);
  import dps_pkg::*;

  localparam logic signed [R_W-1:0] PI_R     = R_W'(PI_FIX_L);
  localparam logic [R_W-1:0]        TWO_PI_U = R_W'(TWO_PI_FIX_L);
  localparam logic [R_W-1:0]        DVS_INIT = TWO_PI_U << WRAP_SHIFT;

  localparam logic signed [ACC_W-1:0] RATE_HI = ACC_W'({1'b0, {(RATE_W - 1){1'b1}}});
  localparam logic signed [ACC_W-1:0] RATE_LO = ~RATE_HI;

  localparam int P_W = T_W - Q30;
  localparam logic signed [P_W-1:0] PIX_HI   = P_W'({1'b0, {(COORD_W - 1){1'b1}}});
  localparam logic signed [P_W-1:0] PIX_LO   = ~PIX_HI;
  localparam logic signed [T_W-1:0] PIX_BIAS = T_W'({Q30{1'b1}});

  // Configuration registers.
  logic [COEF_W-1:0]         stiffness;
  logic [COEF_W-1:0]         damping;
  logic [PIX_W-1:0]          center_x;
  logic [PIX_W-1:0]          center_y;
  logic [PIX_W-1:0]          arm_length;
  logic signed [START_W-1:0] start_angle;

  // Pendulum state.
  logic signed [ANG_W-1:0]   angle;
  logic signed [RATE_W-1:0]  rate;
  logic signed [COORD_W-1:0] last_x;
  logic signed [COORD_W-1:0] last_y;

  // Working registers.
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic [R_W-1:0]            mag;
  logic [R_W-1:0]            dvs;
  logic                      wneg;
  logic [WCNT_W-1:0]         wcnt;
  logic signed [T_W-1:0]     tx;
  logic signed [T_W-1:0]     ty;
  logic                      out_valid;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;

  // Combinational signals.
  logic                      cordic_done;
  logic signed [XY_W-1:0]    sin_q;
  logic signed [XY_W-1:0]    cos_q;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [ACC_W-1:0]   k_term;
  logic signed [ACC_W-1:0]   d_term;
  logic signed [ACC_W-1:0]   rate_sum;
  logic signed [RATE_W-1:0]  rate_sat;
  logic signed [R_W-1:0]     wrap_in;
  logic signed [ANG_W-1:0]   angle_wrapped;
  logic signed [T_W-1:0]     cx_t;
  logic signed [T_W-1:0]     cy_t;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic                      differs;
  logic                      out_free;
  logic                      out_load;

  // Truncate a Q30 coordinate toward zero and clamp it to the output range.
  function automatic logic signed [COORD_W-1:0] pixel(input logic signed [T_W-1:0] t);
    logic signed [T_W-1:0] adj;
    logic signed [P_W-1:0] p;
    logic signed [COORD_W-1:0] r;
    adj = t[T_W-1] ? t + PIX_BIAS : t;
    p   = $signed(adj[T_W-1:Q30]);
    if (p > PIX_HI) begin
      r = COORD_W'(PIX_HI);
    end else if (p < PIX_LO) begin
      r = COORD_W'(PIX_LO);
    end else begin
      r = COORD_W'(p);
    end
    return r;
  endfunction

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness   <= STIFF_RESET;
      damping     <= DAMP_RESET;
      center_x    <= CX_RESET;
      center_y    <= CY_RESET;
      arm_length  <= ARM_RESET;
      start_angle <= START_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_STIFFNESS:   stiffness   <= wr_data[COEF_W-1:0];
        REG_DAMPING:     damping     <= wr_data[COEF_W-1:0];
        REG_CENTER_X:    center_x    <= wr_data[PIX_W-1:0];
        REG_CENTER_Y:    center_y    <= wr_data[PIX_W-1:0];
        REG_ARM_LENGTH:  arm_length  <= wr_data[PIX_W-1:0];
        REG_START_ANGLE: start_angle <= $signed(wr_data[START_W-1:0]);
        default: ;
      endcase
    end
  end

  // Sine and cosine of the current angle.
  dps_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (op == OP_CORDIC_START),
    .angle (angle),
    .done  (cordic_done),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    case (op)
      OP_MUL_D: begin
        mul_a = $signed({1'b0, damping});
        mul_b = MUL_B_W'(rate);
      end
      OP_MUL_X: begin
        mul_a = $signed(MUL_A_W'(arm_length));
        mul_b = sin_q;
      end
      OP_MUL_Y: begin
        mul_a = $signed(MUL_A_W'(arm_length));
        mul_b = cos_q;
      end
      default: begin
        mul_a = $signed({1'b0, stiffness});
        mul_b = sin_q;
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // Acceleration terms and the saturated new rate.
  assign k_term   = ACC_W'(prod >>> K_SHIFT);
  assign d_term   = ACC_W'(prod >>> D_SHIFT);
  assign rate_sum = ACC_W'(rate) + acc;

  always_comb begin
    if (rate_sum > RATE_HI) begin
      rate_sat = RATE_W'(RATE_HI);
    end else if (rate_sum < RATE_LO) begin
      rate_sat = RATE_W'(RATE_LO);
    end else begin
      rate_sat = RATE_W'(rate_sum);
    end
  end

  // Value to wrap, offset by pi so the remainder lands in [0, 2*pi).
  assign wrap_in = (op == OP_WRAP_INIT_RESTART) ? R_W'(start_angle) + PI_R
                                                : R_W'(angle) + R_W'(rate) + PI_R;
  assign angle_wrapped = ANG_W'($signed(mag) - PI_R);

  // Bob coordinates and the change test against the stored position.
  assign cx_t     = $signed(T_W'(center_x) << Q30);
  assign cy_t     = $signed(T_W'(center_y) << Q30);
  assign px       = pixel(tx);
  assign py       = pixel(ty);
  assign differs  = (px != last_x) || (py != last_y);
  assign out_free = !out_valid || bob.ready;
  assign out_load = (op == OP_EMIT) && differs && out_free;

  // Multiplier, accumulator, wrap unit and coordinate registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt <= '0;
    end else begin
      case (op)
        OP_MUL_K: begin
          prod <= prod_next;
        end
        OP_MUL_D: begin
          acc  <= -k_term;
          prod <= prod_next;
        end
        OP_ACC_D: begin
          acc <= acc - d_term;
        end
        OP_WRAP_INIT_STEP, OP_WRAP_INIT_RESTART: begin
          wneg <= wrap_in[R_W-1];
          mag  <= wrap_in[R_W-1] ? R_W'(-wrap_in) : R_W'(wrap_in);
          dvs  <= DVS_INIT;
          wcnt <= WCNT_W'(WRAP_STEPS);
        end
        OP_WRAP_STEP: begin
          if (wcnt != '0) begin
            if (mag >= dvs) begin
              mag <= mag - dvs;
            end
            dvs  <= dvs >> 1;
            wcnt <= wcnt - 1'b1;
          end
        end
        OP_WRAP_FIX: begin
          if (wneg && (mag != '0)) begin
            mag <= TWO_PI_U - mag;
          end
        end
        OP_MUL_X: begin
          prod <= prod_next;
        end
        OP_MUL_Y: begin
          tx   <= cx_t + T_W'(prod);
          prod <= prod_next;
        end
        OP_SUM_Y: begin
          ty <= cy_t - T_W'(prod);
        end
        default: ;
      endcase
    end
  end

  // Pendulum state.
  always_ff @(posedge clk) begin
    if (rst) begin
      angle  <= '0;
      rate   <= '0;
      last_x <= '0;
      last_y <= '0;
    end else begin
      if (op == OP_COMMIT_STEP) begin
        angle <= angle_wrapped;
        rate  <= rate_sat;
      end else if (op == OP_COMMIT_RESTART) begin
        angle <= angle_wrapped;
        rate  <= '0;
      end
      if (out_load) begin
        last_x <= px;
        last_y <= py;
      end
    end
  end

  // Output register: holds a result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      out_x     <= px;
      out_y     <= py;
    end else if (bob.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign bob.valid = out_valid;
  assign bob.bob_x = out_x;
  assign bob.bob_y = out_y;

  // Status back to the controller.
  assign status.cordic_done = cordic_done;
  assign status.wrap_done   = (wcnt == '0);
  assign status.differs     = differs;
  assign status.out_free    = out_free;

endmodule

`default_nettype wire

// ===== hw/rtl/dps_ctrl.sv =====
// Controller of the damped pendulum step block: accepts one tick at a time
// and sequences the datapath operations. Depends on dps_pkg and dps_if.
`default_nettype none

module dps_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  dps_tick_if.sink              tick,
  output dps_pkg::dps_op_t      op,
  input  dps_pkg::dps_status_t  status
);
  import dps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RS_INIT,
    S_C1_START,
    S_C1_RUN,
    S_MUL_K,
    S_MUL_D,
    S_ACC_D,
    S_WRAP_INIT,
    S_WRAP,
    S_FIX,
    S_COMMIT,
    S_C2_START,
    S_C2_RUN,
    S_MUL_X,
    S_MUL_Y,
    S_SUM_Y,
    S_EMIT
  } state_t;

  state_t state;
  logic   is_restart;

  assign tick.ready = (state == S_IDLE);

  // State register and the restart flag of the transaction in progress.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      is_restart <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (tick.valid) begin
            is_restart <= tick.restart;
            state      <= tick.restart ? S_RS_INIT : S_C1_START;
          end
        end
        S_RS_INIT:   state <= S_WRAP;
        S_C1_START:  state <= S_C1_RUN;
        S_C1_RUN:    if (status.cordic_done) state <= S_MUL_K;
        S_MUL_K:     state <= S_MUL_D;
        S_MUL_D:     state <= S_ACC_D;
        S_ACC_D:     state <= S_WRAP_INIT;
        S_WRAP_INIT: state <= S_WRAP;
        S_WRAP:      if (status.wrap_done) state <= S_FIX;
        S_FIX:       state <= S_COMMIT;
        S_COMMIT:    state <= is_restart ? S_IDLE : S_C2_START;
        S_C2_START:  state <= S_C2_RUN;
        S_C2_RUN:    if (status.cordic_done) state <= S_MUL_X;
        S_MUL_X:     state <= S_MUL_Y;
        S_MUL_Y:     state <= S_SUM_Y;
        S_SUM_Y:     state <= S_EMIT;
        S_EMIT: begin
          // Leave once the position is unchanged or the result has a slot.
          if (!status.differs || status.out_free) begin
            state <= S_IDLE;
          end
        end
        default:     state <= S_IDLE;
      endcase
    end
  end

  // Operation decode.
  always_comb begin
    case (state)
      S_RS_INIT:   op = OP_WRAP_INIT_RESTART;
      S_C1_START:  op = OP_CORDIC_START;
      S_MUL_K:     op = OP_MUL_K;
      S_MUL_D:     op = OP_MUL_D;
      S_ACC_D:     op = OP_ACC_D;
      S_WRAP_INIT: op = OP_WRAP_INIT_STEP;
      S_WRAP:      op = OP_WRAP_STEP;
      S_FIX:       op = OP_WRAP_FIX;
      S_COMMIT:    op = is_restart ? OP_COMMIT_RESTART : OP_COMMIT_STEP;
      S_C2_START:  op = OP_CORDIC_START;
      S_MUL_X:     op = OP_MUL_X;
      S_MUL_Y:     op = OP_MUL_Y;
      S_SUM_Y:     op = OP_SUM_Y;
      S_EMIT:      op = OP_EMIT;
      default:     op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dps_checker.sv =====
// Port-level checks of the damped pendulum step block and the bind that
// attaches them to the top level. Depends on dps_pkg.
`default_nettype none

module dps_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             tick_valid,
  input logic                             tick_ready,
  input logic                             tick_restart,
  input logic                             bob_valid,
  input logic                             bob_ready,
  input logic signed [dps_pkg::COORD_W-1:0] bob_x,
  input logic signed [dps_pkg::COORD_W-1:0] bob_y
);
  import dps_pkg::*;

  // A stalled result stays offered.
  a_bob_hold: assert property (@(posedge clk) disable iff (rst)
    (bob_valid && !bob_ready) |=> bob_valid)
    else $error("bob valid dropped while stalled");

  // A stalled result keeps its payload.
  a_bob_stable: assert property (@(posedge clk) disable iff (rst)
    (bob_valid && !bob_ready) |=> ($stable(bob_x) && $stable(bob_y)))
    else $error("bob payload changed while stalled");

  // Only one tick is in flight at a time.
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && tick_ready) |=> !tick_ready)
    else $error("tick accepted while another is in progress");

  // A restart tick accepted while no result is offered does not raise bob valid right after acceptance.
  a_restart_silent: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && tick_ready && tick_restart && !bob_valid) |=> !bob_valid)
    else $error("result appeared after a restart tick");

  // A new result is produced only while a tick is being worked on.
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(bob_valid) |-> $past(!tick_ready))
    else $error("result appeared while the block was idle");

endmodule

bind damped_pendulum_step_top dps_checker u_dps_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_valid   (tick.valid),
  .tick_ready   (tick.ready),
  .tick_restart (tick.restart),
  .bob_valid    (bob.valid),
  .bob_ready    (bob.ready),
  .bob_x        (bob.bob_x),
  .bob_y        (bob.bob_y)
);

`default_nettype wire
